[sv/szar_pkg.sv]
// Shared constants, codes and types of the sensor z-score anomaly router.
// No dependencies; szar_mul, the top level and the checker import this package.
package szar_pkg;

  localparam int TEMP_SENSORS     = 3;
  localparam int HUMIDITY_SENSORS = 2;
  localparam int WINDOW_LEN       = 5;
  localparam int BATCH_DEPTH      = 10;

  localparam int NSLOTS    = TEMP_SENSORS + HUMIDITY_SENSORS + 1;
  localparam int SLW       = $clog2(NSLOTS);
  localparam int PSW       = $clog2(WINDOW_LEN);
  localparam int MW        = $clog2(WINDOW_LEN + 1);
  localparam int WIN_DEPTH = NSLOTS * WINDOW_LEN;
  localparam int WAW       = $clog2(WIN_DEPTH);
  localparam int BAW       = (BATCH_DEPTH > 1) ? $clog2(BATCH_DEPTH) : 1;
  localparam int FILLW     = $clog2(BATCH_DEPTH + 1);

  localparam int VW   = 16;
  localparam int NW   = 24;
  localparam int SW   = 40;
  localparam int QW   = 56;
  localparam int TW   = 17;
  localparam int BEW  = 26;
  localparam int STW  = PSW + NW + SW + QW;
  localparam int ASW  = VW + $clog2(WINDOW_LEN) + 1;
  localparam int NVW  = NW + VW;
  localparam int DW   = NVW + 1;
  localparam int BW80 = 2 * SW;
  localparam int TMPW = 112;

  // Shared multiplier: wide operand, narrow operand consumed four bits a step.
  localparam int MAW = 80;
  localparam int MBW = 4 * ((DW + 3) / 4);
  localparam int MPW = MAW + MBW;
  localparam int MCW = 4;

  localparam int DIG_V  = (VW + 3) / 4;
  localparam int DIG_N  = (NW + 3) / 4;
  localparam int DIG_S  = (SW + 3) / 4;
  localparam int DIG_F  = 4;
  localparam int DIG_D  = (DW + 3) / 4;
  localparam int DIG_T2 = 8;

  localparam logic [NW-1:0] COUNT_MAX   = '1;
  localparam logic [TW-1:0] TICK_MAX    = '1;
  localparam int            FLOOR_MUL   = 15625;
  localparam int            FLOOR_SHIFT = 10;

  localparam logic [15:0] ANOM_THR_RST   = 16'd768;
  localparam logic [15:0] MOTION_THR_RST = 16'd128;
  localparam logic [15:0] TIMEOUT_RST    = 16'd5000;

  localparam logic [1:0] CFG_ANOMALY = 2'd0;
  localparam logic [1:0] CFG_MOTION  = 2'd1;
  localparam logic [1:0] CFG_TIMEOUT = 2'd2;

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_TICK   = 1'b1;
  localparam logic RES_VERDICT = 1'b0;
  localparam logic RES_BATCH   = 1'b1;

  localparam logic [1:0] TYPE_TEMP   = 2'd0;
  localparam logic [1:0] TYPE_HUMID  = 2'd1;
  localparam logic [1:0] TYPE_MOTION = 2'd2;

  localparam logic [2:0] ROUTE_MOTION  = 3'd0;
  localparam logic [2:0] ROUTE_ANOMALY = 3'd1;
  localparam logic [2:0] ROUTE_BATCHED = 3'd2;
  localparam logic [2:0] ROUTE_DROPPED = 3'd3;
  localparam logic [2:0] ROUTE_INVALID = 3'd4;

  localparam logic [1:0] PRI_NONE    = 2'd0;
  localparam logic [1:0] PRI_BATCHED = 2'd1;
  localparam logic [1:0] PRI_OTHER   = 2'd2;
  localparam logic [1:0] PRI_MOTION  = 2'd3;

  typedef struct packed {
    logic           start;
    logic [MCW-1:0] ndig;
    logic [MAW-1:0] a;
    logic [MBW-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic           done;
    logic [MPW-1:0] prod;
  } mul_rsp_t;

endpackage

[sv/szar_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module szar_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[sv/szar_mul.sv]
// Shared digit-serial multiplier: four bits of the narrow operand per cycle.
// Depends on szar_pkg for widths and the request and response structs.
module szar_mul (
  input  logic               clk,
  input  logic               rst_n,
  input  szar_pkg::mul_req_t req,
  output szar_pkg::mul_rsp_t rsp
);
  import szar_pkg::*;

  logic [MPW-1:0]   acc_r;
  logic [MAW-1:0]   a_r;
  logic [MBW-1:0]   b_r;
  logic [MCW-1:0]   cnt_r;
  logic             done_r;
  logic [MAW+3:0]   pp;

  assign pp = a_r * b_r[MBW-1 -: 4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        cnt_r <= req.ndig;
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == MCW'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
    // The narrow operand is left-aligned so its top digit is always consumed first.
    if (req.start) begin
      acc_r <= '0;
      a_r   <= req.a;
      b_r   <= req.b << (MBW - 4 * int'(req.ndig));
    end else if (cnt_r != '0) begin
      acc_r <= (acc_r << 4) + MPW'(pp);
      b_r   <= b_r << 4;
    end
  end

  assign rsp.done = done_r;
  assign rsp.prod = acc_r;

endmodule

[sv/sensor_zscore_anomaly_router_top.sv]
// Top level of the sensor z-score anomaly router.
// Depends on szar_pkg, szar_ram and szar_mul.
//
// Usage. Items enter on the in_ channel (valid/stall); an item transfers at a
// rising edge where in_valid is high and in_stall is low. A sample item gets
// exactly one verdict on the out_ channel. A tick item advances the flush
// timer and, once the timeout has passed with messages pending, releases the
// whole batch as one result per stored message, the final one marked by
// out_last. Registers are written through cfg_we/cfg_index/cfg_data; the user
// must write them only while the block is idle, as the block does not enforce it.
// Processing. The block accepts no new item while one is in progress. The anomaly
// test runs nine products through one digit-serial multiplier (four bits of
// the narrow operand per cycle), the window mean reads the window RAM one
// entry a cycle and divides with a one-bit-per-cycle restoring divider.
// Samples seen before the window is full skip most of the products.
// in_stall is high while an item is in progress.
// Reset (synchronous, active low) clears statistics through per-slot valid
// bits, empties the batch and reloads the register defaults. When the
// receiver stalls, the result waits in the output register; a following
// sample may still be accepted and processed up to its own result.
module sensor_zscore_anomaly_router_top (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_kind,
  input  logic [1:0]        in_sensor_type,
  input  logic [7:0]        in_sensor_id,
  input  logic signed [15:0] in_sample_value,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_result_kind,
  output logic [2:0]        out_route,
  output logic              out_anomaly,
  output logic signed [15:0] out_moving_average,
  output logic [1:0]        out_msg_type,
  output logic [7:0]        out_msg_sensor_id,
  output logic signed [15:0] out_msg_value,
  output logic [1:0]        out_priority_res,
  output logic              out_last,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [15:0]       cfg_data
);
  import szar_pkg::*;

  localparam int DCW = $clog2(ASW + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_CAP, S_MGO, S_MWT, S_UPD, S_SUM, S_DIV, S_OUT, S_RRD, S_ROUT
  } state_t;

  // Order of the products of the anomaly test.
  typedef enum logic [3:0] {
    MS_VV, MS_NQ, MS_SS, MS_LHS, MS_NN, MS_NV, MS_DEV, MS_T2, MS_RHS
  } mstep_t;

  state_t state_r;
  mstep_t mstep_r;

  // Configuration registers.
  logic [15:0] athr_r, mthr_r, tout_r;

  // Control state.
  logic              out_valid_r;
  logic [FILLW-1:0]  fill_r, rel_i_r;
  logic [TW-1:0]     ticks_r;
  logic [NSLOTS-1:0] vld_r;
  logic [MW-1:0]     i_r, m_r;
  logic              pend_r, inv_r;
  logic [DCW-1:0]    dcnt_r;

  // Item payload and working registers.
  logic [1:0]     ty_r;
  logic [7:0]     id_r;
  logic [VW-1:0]  v_r;
  logic [SLW-1:0] slot_r;
  logic [WAW-1:0] base_r;
  logic [NW-1:0]  n_r;
  logic [SW-1:0]  s_r;
  logic [QW-1:0]  q_r;
  logic [PSW-1:0] pos_r;
  logic [31:0]    vv_r, t2_r;
  logic [TMPW-1:0] tmp_r;
  logic [BW80-1:0] b_r;
  logic [DW-1:0]  d_r;
  logic           an_r;
  logic [ASW-1:0] wsum_r, dvd_r;
  logic [MW-1:0]  rem_r;
  logic           neg_r;

  // Output registers.
  logic        o_kind_r, o_an_r, o_last_r;
  logic [2:0]  o_route_r;
  logic [15:0] o_avg_r, o_val_r;
  logic [1:0]  o_type_r, o_pri_r;
  logic [7:0]  o_id_r;

  // Memories and multiplier.
  logic             st_re, st_we, win_re, win_we, bat_re, bat_we;
  logic [SLW-1:0]   st_raddr;
  logic [STW-1:0]   st_rdata, st_wdata;
  logic [WAW-1:0]   win_raddr, win_waddr;
  logic [VW-1:0]    win_rdata;
  logic [BEW-1:0]   bat_rdata, bat_wdata;
  mul_req_t         mreq;
  mul_rsp_t         mrsp;

  // Combinational helpers.
  logic             acc_in, out_free, imm;
  logic             in_ok;
  logic [SLW-1:0]   in_slot;
  logic [TW-1:0]    tick_inc;
  logic [VW-1:0]    vmag;
  logic [SW-1:0]    smag;
  logic [DW:0]      snv, dsig;
  logic [DW-1:0]    dmag;
  logic             sat_ok;
  logic [NW-1:0]    n_new;
  logic [SW-1:0]    s_new;
  logic [QW-1:0]    q_new;
  logic [PSW-1:0]   pos_new;
  logic [MW:0]      rem_sh;
  logic             div_ge;
  logic [ASW-1:0]   avg_q, wsum_mag;

  assign acc_in   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  // Slot mapping: temperature ids first, humidity next, motion in the last slot.
  always_comb begin
    in_ok   = 1'b1;
    in_slot = SLW'(NSLOTS - 1);
    if (in_sensor_type == TYPE_TEMP && in_sensor_id < 8'(TEMP_SENSORS)) begin
      in_slot = SLW'(in_sensor_id);
    end else if (in_sensor_type == TYPE_HUMID && in_sensor_id < 8'(HUMIDITY_SENSORS)) begin
      in_slot = SLW'(TEMP_SENSORS) + SLW'(in_sensor_id);
    end else if (in_sensor_type == TYPE_MOTION) begin
      in_slot = SLW'(NSLOTS - 1);
    end else begin
      in_ok = 1'b0;
    end
  end

  assign tick_inc = (ticks_r < TICK_MAX) ? ticks_r + 1'b1 : ticks_r;

  assign vmag = v_r[VW-1] ? (~v_r + 1'b1) : v_r;
  assign smag = s_r[SW-1] ? (~s_r + 1'b1) : s_r;

  // Deviation n*v - S from the magnitude product n*|v|.
  assign snv  = v_r[VW-1] ? (~{2'b00, mrsp.prod[NVW-1:0]} + 1'b1)
                          : {2'b00, mrsp.prod[NVW-1:0]};
  assign dsig = snv - {{2{s_r[SW-1]}}, s_r};
  assign dmag = dsig[DW] ? DW'(~dsig + 1'b1) : dsig[DW-1:0];

  // Statistics update; the sums and the count freeze once the count saturates.
  assign sat_ok  = (n_r < COUNT_MAX);
  assign n_new   = sat_ok ? n_r + 1'b1 : n_r;
  assign s_new   = sat_ok ? s_r + {{(SW-VW){v_r[VW-1]}}, v_r} : s_r;
  assign q_new   = sat_ok ? q_r + QW'(vv_r) : q_r;
  assign pos_new = (pos_r == PSW'(WINDOW_LEN - 1)) ? '0 : pos_r + 1'b1;

  assign rem_sh = {rem_r, dvd_r[ASW-1]};
  assign div_ge = (rem_sh >= {1'b0, m_r});
  assign avg_q  = neg_r ? (~dvd_r + 1'b1) : dvd_r;
  assign wsum_mag = wsum_r[ASW-1] ? (~wsum_r + 1'b1) : wsum_r;

  assign imm = (ty_r == TYPE_MOTION && $signed(v_r) > $signed(mthr_r)) || an_r;

  // Operand selection for the shared multiplier.
  always_comb begin
    mreq.start = (state_r == S_MGO);
    mreq.ndig  = MCW'(DIG_V);
    mreq.a     = MAW'(vmag);
    mreq.b     = MBW'(vmag);
    case (mstep_r)
      MS_VV: begin
        mreq.ndig = MCW'(DIG_V);
        mreq.a    = MAW'(vmag);
        mreq.b    = MBW'(vmag);
      end
      MS_NQ: begin
        mreq.ndig = MCW'(DIG_N);
        mreq.a    = MAW'(q_r);
        mreq.b    = MBW'(n_r);
      end
      MS_SS: begin
        mreq.ndig = MCW'(DIG_S);
        mreq.a    = MAW'(smag);
        mreq.b    = MBW'(smag);
      end
      MS_LHS: begin
        mreq.ndig = MCW'(DIG_F);
        mreq.a    = MAW'(b_r);
        mreq.b    = MBW'(FLOOR_MUL);
      end
      MS_NN: begin
        mreq.ndig = MCW'(DIG_N);
        mreq.a    = MAW'(n_r);
        mreq.b    = MBW'(n_r);
      end
      MS_NV: begin
        mreq.ndig = MCW'(DIG_V);
        mreq.a    = MAW'(n_r);
        mreq.b    = MBW'(vmag);
      end
      MS_DEV: begin
        mreq.ndig = MCW'(DIG_D);
        mreq.a    = MAW'(d_r);
        mreq.b    = MBW'(d_r);
      end
      MS_T2: begin
        mreq.ndig = MCW'(DIG_V);
        mreq.a    = MAW'(athr_r);
        mreq.b    = MBW'(athr_r);
      end
      MS_RHS: begin
        mreq.ndig = MCW'(DIG_T2);
        mreq.a    = MAW'(b_r);
        mreq.b    = MBW'(t2_r);
      end
      default: begin
        mreq.ndig = MCW'(DIG_V);
      end
    endcase
  end

  // Memory port control.
  assign st_re     = acc_in && (in_kind == KIND_SAMPLE) && in_ok;
  assign st_raddr  = in_slot;
  assign st_we     = (state_r == S_UPD);
  assign st_wdata  = {pos_new, n_new, s_new, q_new};
  assign win_we    = (state_r == S_UPD);
  assign win_waddr = base_r + WAW'(pos_r);
  assign win_re    = (state_r == S_SUM) && (i_r < m_r);
  assign win_raddr = base_r + WAW'(i_r);
  assign bat_we    = (state_r == S_OUT) && out_free && !inv_r && !imm
                     && (fill_r < FILLW'(BATCH_DEPTH));
  assign bat_wdata = {ty_r, id_r, v_r};
  assign bat_re    = (state_r == S_RRD);

  szar_ram #(.WIDTH(STW), .DEPTH(NSLOTS)) u_stats (
    .clk(clk), .we(st_we), .waddr(slot_r), .wdata(st_wdata),
    .re(st_re), .raddr(st_raddr), .rdata(st_rdata)
  );

  szar_ram #(.WIDTH(VW), .DEPTH(WIN_DEPTH)) u_window (
    .clk(clk), .we(win_we), .waddr(win_waddr), .wdata(v_r),
    .re(win_re), .raddr(win_raddr), .rdata(win_rdata)
  );

  szar_ram #(.WIDTH(BEW), .DEPTH(BATCH_DEPTH)) u_batch (
    .clk(clk), .we(bat_we), .waddr(fill_r[BAW-1:0]), .wdata(bat_wdata),
    .re(bat_re), .raddr(rel_i_r[BAW-1:0]), .rdata(bat_rdata)
  );

  szar_mul u_mul (
    .clk(clk), .rst_n(rst_n), .req(mreq), .rsp(mrsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mstep_r     <= MS_VV;
      athr_r      <= ANOM_THR_RST;
      mthr_r      <= MOTION_THR_RST;
      tout_r      <= TIMEOUT_RST;
      out_valid_r <= 1'b0;
      fill_r      <= '0;
      rel_i_r     <= '0;
      ticks_r     <= '0;
      vld_r       <= '0;
      i_r         <= '0;
      m_r         <= '0;
      pend_r      <= 1'b0;
      inv_r       <= 1'b0;
      dcnt_r      <= '0;
    end else begin
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      if (cfg_we) begin
        case (cfg_index)
          CFG_ANOMALY: athr_r <= cfg_data;
          CFG_MOTION:  mthr_r <= cfg_data;
          CFG_TIMEOUT: tout_r <= cfg_data;
          default: ;
        endcase
      end

      case (state_r)
        S_IDLE: begin
          if (acc_in) begin
            if (in_kind == KIND_TICK) begin
              ticks_r <= tick_inc;
              if (fill_r != '0 && tick_inc > {1'b0, tout_r}) begin
                rel_i_r <= '0;
                state_r <= S_RRD;
              end
            end else begin
              ty_r   <= in_sensor_type;
              id_r   <= in_sensor_id;
              v_r    <= in_sample_value;
              slot_r <= in_slot;
              inv_r  <= !in_ok;
              state_r <= in_ok ? S_CAP : S_OUT;
            end
          end
        end

        S_CAP: begin
          // A slot never written since reset reads as all zero.
          if (vld_r[slot_r]) begin
            q_r   <= st_rdata[QW-1:0];
            s_r   <= st_rdata[QW +: SW];
            n_r   <= st_rdata[QW+SW +: NW];
            pos_r <= st_rdata[QW+SW+NW +: PSW];
          end else begin
            q_r   <= '0;
            s_r   <= '0;
            n_r   <= '0;
            pos_r <= '0;
          end
          base_r  <= WAW'(slot_r) * WAW'(WINDOW_LEN);
          an_r    <= 1'b0;
          mstep_r <= MS_VV;
          state_r <= S_MGO;
        end

        S_MGO: begin
          state_r <= S_MWT;
        end

        S_MWT: begin
          if (mrsp.done) begin
            state_r <= S_MGO;
            case (mstep_r)
              MS_VV: begin
                vv_r <= mrsp.prod[31:0];
                if (n_r < NW'(WINDOW_LEN)) begin
                  state_r <= S_UPD;
                end else begin
                  mstep_r <= MS_NQ;
                end
              end
              MS_NQ: begin
                tmp_r   <= mrsp.prod[TMPW-1:0];
                mstep_r <= MS_SS;
              end
              MS_SS: begin
                // No spread at all counts as normal.
                if (tmp_r[BW80-1:0] <= mrsp.prod[BW80-1:0]) begin
                  state_r <= S_UPD;
                end else begin
                  b_r     <= tmp_r[BW80-1:0] - mrsp.prod[BW80-1:0];
                  mstep_r <= MS_LHS;
                end
              end
              MS_LHS: begin
                tmp_r   <= mrsp.prod[TMPW-1:0];
                mstep_r <= MS_NN;
              end
              MS_NN: begin
                // Deviation floor: a tiny spread counts as normal.
                if (tmp_r < TMPW'({mrsp.prod[2*NW-1:0], {FLOOR_SHIFT{1'b0}}})) begin
                  state_r <= S_UPD;
                end else begin
                  mstep_r <= MS_NV;
                end
              end
              MS_NV: begin
                d_r     <= dmag;
                mstep_r <= MS_DEV;
              end
              MS_DEV: begin
                tmp_r   <= mrsp.prod[TMPW-1:0];
                mstep_r <= MS_T2;
              end
              MS_T2: begin
                t2_r    <= mrsp.prod[31:0];
                mstep_r <= MS_RHS;
              end
              MS_RHS: begin
                an_r    <= (TMPW'({tmp_r[2*DW-1:0], 16'h0000}) > mrsp.prod[TMPW-1:0]);
                state_r <= S_UPD;
              end
              default: begin
                state_r <= S_UPD;
              end
            endcase
          end
        end

        S_UPD: begin
          vld_r[slot_r] <= 1'b1;
          m_r     <= (n_new < NW'(WINDOW_LEN)) ? MW'(n_new) : MW'(WINDOW_LEN);
          i_r     <= '0;
          pend_r  <= 1'b0;
          wsum_r  <= '0;
          state_r <= S_SUM;
        end

        S_SUM: begin
          if (pend_r) begin
            wsum_r <= wsum_r + {{(ASW-VW){win_rdata[VW-1]}}, win_rdata};
          end
          pend_r <= (i_r < m_r);
          if (i_r < m_r) begin
            i_r <= i_r + 1'b1;
          end else if (!pend_r) begin
            dvd_r   <= wsum_mag;
            neg_r   <= wsum_r[ASW-1];
            rem_r   <= '0;
            dcnt_r  <= DCW'(ASW);
            state_r <= S_DIV;
          end
        end

        S_DIV: begin
          rem_r  <= div_ge ? MW'(rem_sh - {1'b0, m_r}) : rem_sh[MW-1:0];
          dvd_r  <= {dvd_r[ASW-2:0], div_ge};
          dcnt_r <= dcnt_r - 1'b1;
          if (dcnt_r == DCW'(1)) begin
            state_r <= S_OUT;
          end
        end

        S_OUT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            o_kind_r    <= RES_VERDICT;
            o_last_r    <= 1'b1;
            if (inv_r) begin
              o_route_r <= ROUTE_INVALID;
              o_an_r    <= 1'b0;
              o_avg_r   <= '0;
              o_type_r  <= '0;
              o_id_r    <= '0;
              o_val_r   <= '0;
              o_pri_r   <= PRI_NONE;
            end else begin
              o_an_r   <= an_r;
              o_avg_r  <= avg_q[15:0];
              o_type_r <= ty_r;
              o_id_r   <= id_r;
              o_val_r  <= v_r;
              if (imm) begin
                o_route_r <= an_r ? ROUTE_ANOMALY : ROUTE_MOTION;
                o_pri_r   <= (ty_r == TYPE_MOTION) ? PRI_MOTION : PRI_OTHER;
              end else if (fill_r < FILLW'(BATCH_DEPTH)) begin
                o_route_r <= ROUTE_BATCHED;
                o_pri_r   <= PRI_BATCHED;
                fill_r    <= fill_r + 1'b1;
              end else begin
                o_route_r <= ROUTE_DROPPED;
                o_pri_r   <= PRI_NONE;
              end
            end
            state_r <= S_IDLE;
          end
        end

        S_RRD: begin
          state_r <= S_ROUT;
        end

        S_ROUT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            o_kind_r    <= RES_BATCH;
            o_route_r   <= ROUTE_BATCHED;
            o_an_r      <= 1'b0;
            o_avg_r     <= '0;
            o_type_r    <= bat_rdata[BEW-1 -: 2];
            o_id_r      <= bat_rdata[VW +: 8];
            o_val_r     <= bat_rdata[VW-1:0];
            o_pri_r     <= PRI_BATCHED;
            o_last_r    <= (rel_i_r + 1'b1 == fill_r);
            if (rel_i_r + 1'b1 == fill_r) begin
              fill_r  <= '0;
              ticks_r <= '0;
              state_r <= S_IDLE;
            end else begin
              rel_i_r <= rel_i_r + 1'b1;
              state_r <= S_RRD;
            end
          end
        end

        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid          = out_valid_r;
  assign out_result_kind    = o_kind_r;
  assign out_route          = o_route_r;
  assign out_anomaly        = o_an_r;
  assign out_moving_average = o_avg_r;
  assign out_msg_type       = o_type_r;
  assign out_msg_sensor_id  = o_id_r;
  assign out_msg_value      = o_val_r;
  assign out_priority_res   = o_pri_r;
  assign out_last           = o_last_r;

endmodule

[sv/szar_chk.sv]
// Port-level checker for the sensor z-score anomaly router, bound to the top.
// Depends on szar_pkg for route and priority codes.
module szar_chk (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              in_kind,
  input logic              out_valid,
  input logic              out_stall,
  input logic              out_result_kind,
  input logic [2:0]        out_route,
  input logic              out_anomaly,
  input logic signed [15:0] out_moving_average,
  input logic [7:0]        out_msg_sensor_id,
  input logic signed [15:0] out_msg_value,
  input logic [1:0]        out_priority_res,
  input logic              out_last
);
  import szar_pkg::*;

  // A stalled result stays offered.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // A sample transfer keeps the block busy in the next cycle.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_kind == KIND_SAMPLE |=> in_stall)
    else $error("sample accepted without going busy");

  // A verdict is always the single and final result of its sample.
  a_verdict_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind == RES_VERDICT |-> out_last)
    else $error("verdict not marked last");

  // Released messages carry the batched route and priority, with no average.
  a_release: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind == RES_BATCH |->
      out_route == ROUTE_BATCHED && out_priority_res == PRI_BATCHED
      && !out_anomaly && out_moving_average == 16'sd0)
    else $error("bad released message");

  // Invalid samples report nothing but the route.
  a_invalid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_route == ROUTE_INVALID |->
      out_priority_res == PRI_NONE && out_msg_value == 16'sd0
      && out_msg_sensor_id == 8'd0 && !out_anomaly)
    else $error("invalid verdict carries data");

endmodule

bind sensor_zscore_anomaly_router_top szar_chk u_szar_chk (.*);
